// ----- sv/sha1pnh_pkg.sv -----
// Shared types and constants for the SHA-1 prefix/nonce hasher.
`timescale 1ns / 1ps

package sha1pnh_pkg;

  // Configuration index space
  localparam int                 PREFIX_REGS = 5;
  localparam int                 CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 3'd5;

  // Message layout
  localparam logic [5:0] PREFIX_LEN      = 6'd40;
  localparam logic [3:0] MAX_NONCE_BYTES = 4'd15;
  localparam logic [7:0] PAD_BYTE        = 8'h80;

  // SHA-1 initial hash values
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // Round group selects the boolean function and K
  typedef enum logic [1:0] {
    GRP_CH   = 2'd0,
    GRP_PAR1 = 2'd1,
    GRP_MAJ  = 2'd2,
    GRP_PAR2 = 2'd3
  } round_grp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       cfg_write;   // store cfg data into prefix register
    logic       load_init;   // IV into working vars, prefix words into window
    logic       load_item;   // midstate into working vars, padded block into window
    logic       round;       // run one round, shift the schedule window
    logic       use_item_w;  // take W from the item tap of the window
    logic       save_mid;    // capture round result as the new midstate
    logic       finish;      // add IV and load the digest register
    round_grp_t grp;
  } dp_cmd_t;

endpackage

// ----- sv/sha1_prefix_nonce_hasher.sv -----
// Top level of the SHA-1 digest engine over a cached 40-byte prefix plus a nonce.
// A request is loaded, runs rounds 10..79 on the single round unit, and is finished into
// the output register once it is free; no new request is taken until then.
// Reset: clears the prefix registers, then loads the IV and runs rounds 0..9 to
//   rebuild the midstate before in_ready rises; each valid prefix write restarts this rebuild.
// A finished digest sits in the output register while the next request is taken.
`timescale 1ns / 1ps

module sha1_prefix_nonce_hasher #(
  // longest nonce honored; larger lengths saturate to it
  parameter logic [3:0] MAX_NONCE_BYTES = sha1pnh_pkg::MAX_NONCE_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sha1pnh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                         cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [63:0]                         nonce_head,
  input  logic [55:0]                         nonce_tail,
  input  logic [3:0]                          nonce_size,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         digest_high,
  output logic [63:0]                         digest_mid,
  output logic [31:0]                         digest_low
);

  sha1pnh_pkg::dp_cmd_t cmd;

  // Controller: sequences midstate rebuild, item rounds and result handoff.
  // cfg is taken whenever no request is in flight; a write to a valid index
  // restarts the midstate rebuild. Indexes past the last prefix register are
  // accepted and dropped.
  sha1pnh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: prefix storage, block padding, 16-word schedule window,
  // one round per cycle and the digest output register.
  sha1pnh_dpath #(
    .MAX_NONCE_BYTES (MAX_NONCE_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .nonce_head  (nonce_head),
    .nonce_tail  (nonce_tail),
    .nonce_size  (nonce_size),
    .digest_high (digest_high),
    .digest_mid  (digest_mid),
    .digest_low  (digest_low)
  );

  // A new result never overwrites one still waiting to be taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("digest register overwritten while holding an untaken result");

  // Taking a request clears in_ready
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // Datapath load/round/finish commands are mutually exclusive
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_init, cmd.load_item, cmd.round, cmd.finish}))
    else $error("conflicting datapath commands");

  // A request and a prefix write never land on the same edge
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(cfg_valid && cfg_ready))
    else $error("request accepted together with a configuration write");

endmodule

// ----- sv/sha1pnh_ctrl.sv -----
// Sequencing state machine for the SHA-1 prefix/nonce hasher.
`timescale 1ns / 1ps

module sha1pnh_ctrl (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  input  logic [sha1pnh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  output logic                                    cfg_ready,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output sha1pnh_pkg::dp_cmd_t                    cmd
);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_MID  = 5'b00010,
    ST_IDLE = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  localparam logic [6:0] RND_MID_LAST  = 7'd9;
  localparam logic [6:0] RND_RUN_FIRST = 7'd10;
  localparam logic [6:0] RND_RUN_LAST  = 7'd79;
  localparam logic [6:0] RND_GRP1      = 7'd20;
  localparam logic [6:0] RND_GRP2      = 7'd40;
  localparam logic [6:0] RND_GRP3      = 7'd60;

  state_t     state, state_next;
  logic [6:0] rnd, rnd_next;
  logic       out_valid_next;
  logic       cfg_hit;
  logic       in_acc;

  always_comb begin
    cfg_ready = (state == ST_IDLE) || (state == ST_INIT) || (state == ST_MID);
    cfg_hit   = cfg_valid && cfg_ready && (cfg_index < sha1pnh_pkg::REG_COUNT);
    in_ready  = (state == ST_IDLE) && !cfg_valid;
    in_acc    = in_valid && in_ready;
  end

  always_comb begin
    cmd            = '0;
    cmd.cfg_write  = cfg_hit;
    state_next     = state;
    rnd_next       = rnd;
    out_valid_next = out_valid && !out_ready;

    if (rnd < RND_GRP1) begin
      cmd.grp = sha1pnh_pkg::GRP_CH;
    end else if (rnd < RND_GRP2) begin
      cmd.grp = sha1pnh_pkg::GRP_PAR1;
    end else if (rnd < RND_GRP3) begin
      cmd.grp = sha1pnh_pkg::GRP_MAJ;
    end else begin
      cmd.grp = sha1pnh_pkg::GRP_PAR2;
    end

    case (state)
      ST_INIT: begin
        cmd.load_init = 1'b1;
        rnd_next      = '0;
        state_next    = cfg_hit ? ST_INIT : ST_MID;
      end
      ST_MID: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 7'd1;
        if (cfg_hit) begin
          state_next = ST_INIT;
        end else if (rnd == RND_MID_LAST) begin
          cmd.save_mid = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_hit) begin
          state_next = ST_INIT;
        end else if (in_acc) begin
          cmd.load_item = 1'b1;
          rnd_next      = RND_RUN_FIRST;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round      = 1'b1;
        cmd.use_item_w = 1'b1;
        rnd_next       = rnd + 7'd1;
        if (rnd == RND_RUN_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/sha1pnh_dpath.sv -----
// Round datapath, message schedule window and prefix storage for the hasher.
`timescale 1ns / 1ps

module sha1pnh_dpath #(
  parameter logic [3:0] MAX_NONCE_BYTES = sha1pnh_pkg::MAX_NONCE_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sha1pnh_pkg::dp_cmd_t                cmd,
  input  logic [sha1pnh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                         cfg_data,
  input  logic [63:0]                         nonce_head,
  input  logic [55:0]                         nonce_tail,
  input  logic [3:0]                          nonce_size,
  output logic [63:0]                         digest_high,
  output logic [63:0]                         digest_mid,
  output logic [31:0]                         digest_low
);

  logic [63:0] prefix_regs [sha1pnh_pkg::PREFIX_REGS];
  logic [31:0] pw [10];
  logic [31:0] blk [16];
  logic [7:0]  nbyte [15];
  logic [7:0]  tb [24];
  logic [3:0]  len_sat;
  logic [5:0]  total;
  logic [8:0]  bit_len;

  logic [31:0] win [16];
  logic [31:0] w_cur, w_new;
  logic [31:0] va, vb, vc, vd, ve;
  logic [31:0] mid [5];
  logic [31:0] f_val, k_val, temp;

  // Prefix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sha1pnh_pkg::PREFIX_REGS; i++) begin
        prefix_regs[i] <= '0;
      end
    end else if (cmd.cfg_write) begin
      prefix_regs[cfg_index] <= cfg_data;
    end
  end

  // Padded block: prefix words, nonce, 0x80, zeros, 16-bit bit length
  always_comb begin
    for (int i = 0; i < sha1pnh_pkg::PREFIX_REGS; i++) begin
      pw[2*i]   = prefix_regs[i][63:32];
      pw[2*i+1] = prefix_regs[i][31:0];
    end

    len_sat = (nonce_size > MAX_NONCE_BYTES) ? MAX_NONCE_BYTES : nonce_size;

    for (int i = 0; i < 8; i++) begin
      nbyte[i] = nonce_head[63-8*i -: 8];
    end
    for (int i = 0; i < 7; i++) begin
      nbyte[8+i] = nonce_tail[55-8*i -: 8];
    end

    for (int i = 0; i < 24; i++) begin
      tb[i] = 8'h00;
    end
    for (int i = 0; i < 15; i++) begin
      if (4'(i) < len_sat) begin
        tb[i] = nbyte[i];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (4'(i) == len_sat) begin
        tb[i] = sha1pnh_pkg::PAD_BYTE;
      end
    end
    total   = sha1pnh_pkg::PREFIX_LEN + {2'b00, len_sat};
    bit_len = {total, 3'b000};
    tb[22]  = {7'b0000000, bit_len[8]};
    tb[23]  = bit_len[7:0];

    for (int i = 0; i < 10; i++) begin
      blk[i] = pw[i];
    end
    for (int j = 0; j < 6; j++) begin
      blk[10+j] = {tb[4*j], tb[4*j+1], tb[4*j+2], tb[4*j+3]};
    end
  end

  // Schedule window holds W[s..s+15]; item rounds read the tap ten ahead
  always_comb begin
    w_new = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {w_new[30:0], w_new[31]};
    w_cur = cmd.use_item_w ? win[10] : win[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      for (int i = 0; i < 10; i++) begin
        win[i] <= pw[i];
      end
      for (int i = 10; i < 16; i++) begin
        win[i] <= 32'h0;
      end
    end else if (cmd.load_item) begin
      for (int i = 0; i < 16; i++) begin
        win[i] <= blk[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

  // One SHA-1 round
  always_comb begin
    case (cmd.grp)
      sha1pnh_pkg::GRP_CH: begin
        f_val = (vb & vc) | (~vb & vd);
        k_val = sha1pnh_pkg::K0;
      end
      sha1pnh_pkg::GRP_PAR1: begin
        f_val = vb ^ vc ^ vd;
        k_val = sha1pnh_pkg::K1;
      end
      sha1pnh_pkg::GRP_MAJ: begin
        f_val = (vb & vc) | (vb & vd) | (vc & vd);
        k_val = sha1pnh_pkg::K2;
      end
      sha1pnh_pkg::GRP_PAR2: begin
        f_val = vb ^ vc ^ vd;
        k_val = sha1pnh_pkg::K3;
      end
      default: begin
        f_val = vb ^ vc ^ vd;
        k_val = sha1pnh_pkg::K3;
      end
    endcase
    temp = {va[26:0], va[31:27]} + f_val + ve + k_val + w_cur;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      va <= sha1pnh_pkg::H0;
      vb <= sha1pnh_pkg::H1;
      vc <= sha1pnh_pkg::H2;
      vd <= sha1pnh_pkg::H3;
      ve <= sha1pnh_pkg::H4;
    end else if (cmd.load_item) begin
      va <= mid[0];
      vb <= mid[1];
      vc <= mid[2];
      vd <= mid[3];
      ve <= mid[4];
    end else if (cmd.round) begin
      va <= temp;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_mid) begin
      mid[0] <= temp;
      mid[1] <= va;
      mid[2] <= {vb[1:0], vb[31:2]};
      mid[3] <= vc;
      mid[4] <= vd;
    end
  end

  // Digest register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      digest_high <= {va + sha1pnh_pkg::H0, vb + sha1pnh_pkg::H1};
      digest_mid  <= {vc + sha1pnh_pkg::H2, vd + sha1pnh_pkg::H3};
      digest_low  <= ve + sha1pnh_pkg::H4;
    end
  end

endmodule
